// File: rtl/mmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared types and constants for the Montgomery modular multiplier.
// ----------------------------------------------------------------------------
package mmm_pkg;

  localparam int WORD_W  = 32;
  localparam int INDEX_W = 6;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_INV_RD,
    S_INV_GO,
    S_INV_RUN,
    S_CLR,
    S_ROW_RD,
    S_ROW_T,
    S_ROW_A,
    S_MAC_RD,
    S_MAC_MUL,
    S_MAC_ADD,
    S_CAR_RD,
    S_CAR_ADD,
    S_CMP_RD,
    S_CMP_CHK,
    S_OUT_RD,
    S_OUT_CALC,
    S_BAD,
    S_OUT_HOLD
  } state_t;

endpackage
`default_nettype wire

// File: rtl/mmm_inv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmm_inv
// Bit-serial inverse of an odd word mod 2^32; zero for an even word.
// ----------------------------------------------------------------------------
module mmm_inv (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  input  mmm_pkg::word_t m0,
  output logic          done,
  output mmm_pkg::word_t inv
);
  import mmm_pkg::*;

  logic  busy_r, busy_nxt;
  logic  done_r, done_nxt;
  logic  odd_r,  odd_nxt;
  word_t inv_r,  inv_nxt;
  word_t prod_r, prod_nxt;   // low word of inv_r * m0
  word_t msh_r,  msh_nxt;    // m0 shifted to the current bit
  word_t msk_r,  msk_nxt;    // one-hot current bit

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    odd_nxt  = odd_r;
    inv_nxt  = inv_r;
    prod_nxt = prod_r;
    msh_nxt  = msh_r;
    msk_nxt  = msk_r;
    if (start) begin
      busy_nxt = 1'b1;
      odd_nxt  = m0[0];
      inv_nxt  = word_t'(1);
      prod_nxt = m0;
      msh_nxt  = m0 << 1;
      msk_nxt  = word_t'(2);
    end else if (busy_r) begin
      // product is 1 mod 2^j; its bit j decides inverse bit j
      if ((prod_r & msk_r) != '0) begin
        inv_nxt  = inv_r | msk_r;
        prod_nxt = prod_r + msh_r;
      end
      msh_nxt = msh_r << 1;
      msk_nxt = msk_r << 1;
      if (msk_r[WORD_W-1]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odd_r  <= odd_nxt;
    inv_r  <= inv_nxt;
    prod_r <= prod_nxt;
    msh_r  <= msh_nxt;
    msk_r  <= msk_nxt;
  end

  assign done = done_r;
  assign inv  = odd_r ? inv_r : '0;

endmodule
`default_nettype wire

// File: rtl/montgomery_modular_multiplier_core.sv
`default_nettype none
// Loading accepts one item per cycle while idle. The datapath is built
//   around one shared 32x32 multiplier and one accumulator RAM of
//   2*MAX_WORDS+2 words; the factor is derived when the register is zero.
// Throughput: one operation at a time; input is held off until the last
//   result word transfers. Reset (rst_n, synchronous) returns to idle.
// ----------------------------------------------------------------------------
// montgomery_modular_multiplier_core
// Word-serial Montgomery multiplier: loads X, Y, M word by word, forms
// X*Y, runs n word reductions, conditionally subtracts M, emits n words (one flagged word for a zero modulus).
// ----------------------------------------------------------------------------
module montgomery_modular_multiplier_core #(
  parameter int MAX_WORDS = 64
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // configuration
  input  wire                           cfg_wr_en,
  input  mmm_pkg::word_t                cfg_wr_data,
  // operand words
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [mmm_pkg::INDEX_W-1:0]    in_word_index,
  input  mmm_pkg::word_t                in_x_word,
  input  mmm_pkg::word_t                in_y_word,
  input  mmm_pkg::word_t                in_m_word,
  input  wire                           in_last_in,
  // result words
  output logic                          out_valid,
  input  wire                           out_ready,
  output mmm_pkg::word_t                out_result_word,
  output logic [mmm_pkg::INDEX_W-1:0]   out_result_index,
  output logic                          out_last_out,
  output logic                          out_bad_modulus
);
  import mmm_pkg::*;

  localparam int AW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int ACCW = 2 * MAX_WORDS + 2;     // accumulator words
  localparam int PW   = $clog2(ACCW);          // accumulator address
  localparam int QW   = $clog2(ACCW + 1);      // counters

  // operand and accumulator RAMs
  word_t x_mem [MAX_WORDS];
  word_t y_mem [MAX_WORDS];
  word_t m_mem [MAX_WORDS];
  word_t acc_mem [ACCW];

  word_t x_rd_r, y_rd_r, m_rd_r, acc_rd_r;
  logic          x_re, y_re, m_re, acc_re, acc_we, st_we;
  logic [AW-1:0] x_ra, y_ra, m_ra;
  logic [PW-1:0] acc_ra, acc_wa;
  word_t         acc_wd;

  // control
  state_t state_r, state_nxt;
  logic [QW-1:0] wl_r, wl_nxt;       // words loaded
  word_t         cfg_r;
  logic          out_valid_r, out_valid_nxt;

  // datapath
  logic [QW-1:0] len_r, len_nxt, n_r, n_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [QW-1:0] k_r, k_nxt, pos_r, pos_nxt;
  word_t         carry_r, carry_nxt, a_r, a_nxt, factor_r, factor_nxt;
  logic [2*WORD_W-1:0] prod_r, prod_nxt;
  logic          red_r, red_nxt;     // 0: product rows, 1: reduction rows
  logic          ge_r, ge_nxt, borrow_r, borrow_nxt;
  word_t         ow_r, ow_nxt;
  logic [INDEX_W-1:0] oi_r, oi_nxt;
  logic          ol_r, ol_nxt, ob_r, ob_nxt;

  // shared multiplier operands
  logic  mul_en;
  word_t mul_a, mul_b;

  // inverse unit
  logic  inv_start, inv_done;
  word_t inv_w;

  mmm_inv u_inv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (inv_start),
    .m0    (m_rd_r),
    .done  (inv_done),
    .inv   (inv_w)
  );

  // load side
  logic          in_range;
  logic [QW-1:0] wl_cand, len_new;
  logic [QW-1:0] row_len, n_found;
  logic [2*WORD_W-1:0] mac_sum;
  logic [WORD_W:0]     car_sum, diff;
  word_t               mw;

  assign in_ready = (state_r == S_IDLE);
  assign in_range = ({1'b0, in_word_index} < 7'(MAX_WORDS));
  assign wl_cand  = QW'(in_word_index) + QW'(1);
  assign len_new  = (in_range && (wl_cand > wl_r)) ? wl_cand : wl_r;
  assign st_we    = in_valid && in_ready && in_range;
  assign row_len  = red_r ? n_r : len_r;
  assign n_found  = (m_rd_r != '0) ? (k_r + QW'(1)) : n_r;
  assign mac_sum  = prod_r + {{WORD_W{1'b0}}, acc_rd_r} + {{WORD_W{1'b0}}, carry_r};
  assign car_sum  = {1'b0, acc_rd_r} + {1'b0, carry_r};
  assign mw       = (k_r < n_r) ? m_rd_r : '0;
  assign diff     = {1'b0, acc_rd_r} - {1'b0, (ge_r ? m_rd_r : word_t'(0))}
                    - {{WORD_W{1'b0}}, borrow_r};

  always_comb begin
    state_nxt     = state_r;
    wl_nxt        = wl_r;
    out_valid_nxt = out_valid_r;
    len_nxt    = len_r;    n_nxt      = n_r;
    i_nxt      = i_r;      j_nxt      = j_r;
    k_nxt      = k_r;      pos_nxt    = pos_r;
    carry_nxt  = carry_r;  a_nxt      = a_r;
    factor_nxt = factor_r; prod_nxt   = prod_r;
    red_nxt    = red_r;    ge_nxt     = ge_r;
    borrow_nxt = borrow_r;
    ow_nxt = ow_r; oi_nxt = oi_r; ol_nxt = ol_r; ob_nxt = ob_r;
    x_re = 1'b0; y_re = 1'b0; m_re = 1'b0; acc_re = 1'b0; acc_we = 1'b0;
    x_ra = '0;   y_ra = '0;   m_ra = '0;   acc_ra = '0;   acc_wa = '0;
    acc_wd = '0;
    mul_en = 1'b0; mul_a = a_r; mul_b = '0;
    inv_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wl_nxt = len_new;
          if (in_last_in) begin
            len_nxt   = len_new;
            wl_nxt    = '0;
            k_nxt     = '0;
            n_nxt     = '0;
            state_nxt = (len_new == '0) ? S_BAD : S_SCAN_RD;
          end
        end
      end
      // find n: highest nonzero modulus word
      S_SCAN_RD: begin
        m_re      = 1'b1;
        m_ra      = k_r[AW-1:0];
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        n_nxt = n_found;
        if (k_r + QW'(1) == len_r) begin
          k_nxt = '0;
          if (n_found == '0) begin
            state_nxt = S_BAD;
          end else if (cfg_r != '0) begin
            factor_nxt = cfg_r;
            state_nxt  = S_CLR;
          end else begin
            state_nxt = S_INV_RD;
          end
        end else begin
          k_nxt     = k_r + QW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_INV_RD: begin
        m_re      = 1'b1;
        m_ra      = '0;
        state_nxt = S_INV_GO;
      end
      S_INV_GO: begin
        inv_start = 1'b1;
        state_nxt = S_INV_RUN;
      end
      S_INV_RUN: begin
        if (inv_done) begin
          factor_nxt = '0 - inv_w;
          k_nxt      = '0;
          state_nxt  = S_CLR;
        end
      end
      S_CLR: begin
        acc_we = 1'b1;
        acc_wa = k_r[PW-1:0];
        if (k_r == QW'(ACCW - 1)) begin
          i_nxt     = '0;
          red_nxt   = 1'b0;
          state_nxt = S_ROW_RD;
        end else begin
          k_nxt = k_r + QW'(1);
        end
      end
      // row start: X word, or reduction word t = factor * acc
      S_ROW_RD: begin
        if (red_r) begin
          acc_re = 1'b1;
          acc_ra = i_r[PW-1:0];
        end else begin
          x_re = 1'b1;
          x_ra = i_r[AW-1:0];
        end
        state_nxt = S_ROW_T;
      end
      S_ROW_T: begin
        carry_nxt = '0;
        j_nxt     = '0;
        if (red_r) begin
          mul_en    = 1'b1;
          mul_a     = factor_r;
          mul_b     = acc_rd_r;
          state_nxt = S_ROW_A;
        end else begin
          a_nxt     = x_rd_r;
          state_nxt = S_MAC_RD;
        end
      end
      S_ROW_A: begin
        a_nxt     = prod_r[WORD_W-1:0];
        state_nxt = S_MAC_RD;
      end
      S_MAC_RD: begin
        if (red_r) begin
          m_re = 1'b1;
          m_ra = j_r[AW-1:0];
        end else begin
          y_re = 1'b1;
          y_ra = j_r[AW-1:0];
        end
        acc_re    = 1'b1;
        acc_ra    = PW'(i_r + j_r);
        state_nxt = S_MAC_MUL;
      end
      S_MAC_MUL: begin
        mul_en    = 1'b1;
        mul_b     = red_r ? m_rd_r : y_rd_r;
        state_nxt = S_MAC_ADD;
      end
      S_MAC_ADD: begin
        acc_we    = 1'b1;
        acc_wa    = PW'(i_r + j_r);
        acc_wd    = mac_sum[WORD_W-1:0];
        carry_nxt = mac_sum[2*WORD_W-1:WORD_W];
        if (j_r + QW'(1) == row_len) begin
          pos_nxt   = i_r + row_len;
          state_nxt = S_CAR_RD;
        end else begin
          j_nxt     = j_r + QW'(1);
          state_nxt = S_MAC_RD;
        end
      end
      // ripple the row carry upward
      S_CAR_RD: begin
        if ((carry_r == '0) || (pos_r >= QW'(ACCW))) begin
          if (i_r + QW'(1) == row_len) begin
            if (red_r) begin
              k_nxt     = QW'(ACCW - 1) - n_r;
              state_nxt = S_CMP_RD;
            end else begin
              red_nxt   = 1'b1;
              i_nxt     = '0;
              state_nxt = S_ROW_RD;
            end
          end else begin
            i_nxt     = i_r + QW'(1);
            state_nxt = S_ROW_RD;
          end
        end else begin
          acc_re    = 1'b1;
          acc_ra    = pos_r[PW-1:0];
          state_nxt = S_CAR_ADD;
        end
      end
      S_CAR_ADD: begin
        acc_we    = 1'b1;
        acc_wa    = pos_r[PW-1:0];
        acc_wd    = car_sum[WORD_W-1:0];
        carry_nxt = word_t'(car_sum[WORD_W]);
        pos_nxt   = pos_r + QW'(1);
        state_nxt = S_CAR_RD;
      end
      // compare shifted accumulator with M, top word first
      S_CMP_RD: begin
        acc_re    = 1'b1;
        acc_ra    = PW'(n_r + k_r);
        m_re      = 1'b1;
        m_ra      = k_r[AW-1:0];
        state_nxt = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (acc_rd_r != mw) begin
          ge_nxt     = (acc_rd_r > mw);
          k_nxt      = '0;
          borrow_nxt = 1'b0;
          state_nxt  = S_OUT_RD;
        end else if (k_r == '0) begin
          ge_nxt     = 1'b1;
          borrow_nxt = 1'b0;
          state_nxt  = S_OUT_RD;
        end else begin
          k_nxt     = k_r - QW'(1);
          state_nxt = S_CMP_RD;
        end
      end
      // emit with the conditional subtraction folded in
      S_OUT_RD: begin
        acc_re    = 1'b1;
        acc_ra    = PW'(n_r + k_r);
        m_re      = 1'b1;
        m_ra      = k_r[AW-1:0];
        state_nxt = S_OUT_CALC;
      end
      S_OUT_CALC: begin
        ow_nxt        = diff[WORD_W-1:0];
        borrow_nxt    = diff[WORD_W];
        oi_nxt        = INDEX_W'(k_r);
        ol_nxt        = (k_r + QW'(1) == n_r);
        ob_nxt        = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT_HOLD;
      end
      S_BAD: begin
        ow_nxt        = '0;
        oi_nxt        = '0;
        ol_nxt        = 1'b1;
        ob_nxt        = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (ol_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + QW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (mul_en) begin
      prod_nxt = mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= '0;
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;  n_r <= n_nxt;  i_r <= i_nxt;  j_r <= j_nxt;
    k_r   <= k_nxt;    pos_r <= pos_nxt;
    carry_r  <= carry_nxt;  a_r <= a_nxt;  factor_r <= factor_nxt;
    prod_r   <= prod_nxt;   red_r <= red_nxt;
    ge_r     <= ge_nxt;     borrow_r <= borrow_nxt;
    ow_r <= ow_nxt; oi_r <= oi_nxt; ol_r <= ol_nxt; ob_r <= ob_nxt;
  end

  // operand stores
  always_ff @(posedge clk) begin
    if (st_we) begin
      x_mem[in_word_index[AW-1:0]] <= in_x_word;
      y_mem[in_word_index[AW-1:0]] <= in_y_word;
      m_mem[in_word_index[AW-1:0]] <= in_m_word;
    end
    if (x_re) x_rd_r <= x_mem[x_ra];
    if (y_re) y_rd_r <= y_mem[y_ra];
    if (m_re) m_rd_r <= m_mem[m_ra];
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    if (acc_re) acc_rd_r <= acc_mem[acc_ra];
  end

  assign out_valid        = out_valid_r;
  assign out_result_word  = ow_r;
  assign out_result_index = oi_r;
  assign out_last_out     = ol_r;
  assign out_bad_modulus  = ob_r;

endmodule
`default_nettype wire

// File: sim/tb_montgomery_modular_multiplier_core.sv
// ----------------------------------------------------------------------------
// Montgomery multiplier core testbench
// Loads X, Y and M word by word and checks every result word against a
// big-number model of the core's arithmetic. Covers directed corner operands,
// several inverse register settings, random operations with random gaps on
// both channels, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_montgomery_modular_multiplier_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mmm_pkg::*;

  localparam int MAXW      = 64;
  localparam int ACCW      = 2 * MAXW + 2;
  localparam int IDLE_WAIT = 40;       // settle cycles before a register write
  localparam int DOG_LIMIT = 400000;   // cycles without any transfer

  typedef struct {
    word_t             word;
    logic [INDEX_W-1:0] index;
    logic              last;
    logic              bad;
  } result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  word_t              cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [INDEX_W-1:0] in_word_index;
  word_t              in_x_word;
  word_t              in_y_word;
  word_t              in_m_word;
  logic               in_last_in;
  logic               out_valid;
  logic               out_ready;
  word_t              out_result_word;
  logic [INDEX_W-1:0] out_result_index;
  logic               out_last_out;
  logic               out_bad_modulus;

  montgomery_modular_multiplier_core #(.MAX_WORDS(MAXW)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_word_index    (in_word_index),
    .in_x_word        (in_x_word),
    .in_y_word        (in_y_word),
    .in_m_word        (in_m_word),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_word  (out_result_word),
    .out_result_index (out_result_index),
    .out_last_out     (out_last_out),
    .out_bad_modulus  (out_bad_modulus)
  );

  // Predictor state: shadow copy of the operand stores and the register.
  word_t   x_mem [MAXW];
  word_t   y_mem [MAXW];
  word_t   m_mem [MAXW];
  int      loaded_len;
  word_t   neg_inv;          // shadow of the inverse register
  result_t product_q[$];     // result words still to come

  int      errors;
  int      items_sent;
  bit      no_gaps;          // both sides run without idling
  bit      hold_req;         // receiver takes one long stall
  int      dog_count;

  // Operand buffers filled by the test tasks before an operation is sent.
  word_t   op_x [MAXW];
  word_t   op_y [MAXW];
  word_t   op_m [MAXW];

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Inverse of an odd word mod 2^32 by Newton steps; even words give zero.
  function automatic word_t word_inv(input word_t a);
    word_t v;
    if (!a[0]) return '0;
    v = a;                                  // correct to 3 bits for odd a
    for (int s = 0; s < 5; s++) v = v * (32'd2 - a * v);
    return v;
  endfunction

  // Full operation on the shadow stores; pushes the expected result words.
  task automatic predict_product();
    word_t        acc [ACCW];
    int           len, n, p;
    word_t        f, t, mw;
    logic [63:0]  c, t64, d;
    bit           ge;
    logic         borrow;
    result_t      r;
    len = loaded_len;
    loaded_len = 0;
    n = 0;
    for (int i = 0; i < len; i++) if (m_mem[i] != 0) n = i + 1;
    if (n == 0) begin
      // zero modulus: single flagged word
      r.word = '0; r.index = '0; r.last = 1'b1; r.bad = 1'b1;
      product_q.push_back(r);
      return;
    end
    f = (neg_inv != 0) ? neg_inv : (32'd0 - word_inv(m_mem[0]));
    for (int k = 0; k < ACCW; k++) acc[k] = '0;
    // schoolbook product
    for (int i = 0; i < len; i++) begin
      c = '0;
      t64 = {32'd0, x_mem[i]};
      for (int j = 0; j < len; j++) begin
        c = c + t64 * y_mem[j] + acc[i+j];
        acc[i+j] = c[31:0];
        c = c >> 32;
      end
      p = i + len;
      while (c != 0 && p < ACCW) begin
        c = c + acc[p]; acc[p] = c[31:0]; c = c >> 32; p++;
      end
    end
    // n word reductions, each followed by a one-word shift
    for (int i = 0; i < n; i++) begin
      t = f * acc[0];
      t64 = {32'd0, t};
      c = '0;
      for (int j = 0; j < n; j++) begin
        c = c + t64 * m_mem[j] + acc[j];
        acc[j] = c[31:0];
        c = c >> 32;
      end
      p = n;
      while (c != 0 && p < ACCW) begin
        c = c + acc[p]; acc[p] = c[31:0]; c = c >> 32; p++;
      end
      for (int k = 0; k < ACCW - 1; k++) acc[k] = acc[k+1];
      acc[ACCW-1] = '0;
    end
    // final conditional subtraction
    ge = 1'b1;
    for (int k = ACCW - 1; k >= 0; k--) begin
      mw = (k < n) ? m_mem[k] : '0;
      if (acc[k] != mw) begin
        ge = acc[k] > mw;
        break;
      end
    end
    if (ge) begin
      borrow = 1'b0;
      for (int k = 0; k < ACCW; k++) begin
        mw = (k < n) ? m_mem[k] : '0;
        d = {32'd0, acc[k]} - {32'd0, mw} - {63'd0, borrow};
        acc[k] = d[31:0];
        borrow = d[32];
      end
    end
    for (int k = 0; k < n; k++) begin
      r.word = acc[k]; r.index = k[INDEX_W-1:0];
      r.last = (k == n - 1); r.bad = 1'b0;
      product_q.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: load accepted words into the shadow, check each result transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t e;
    if (rst_n && in_valid && in_ready) begin
      x_mem[in_word_index] = in_x_word;
      y_mem[in_word_index] = in_y_word;
      m_mem[in_word_index] = in_m_word;
      if (int'(in_word_index) + 1 > loaded_len) loaded_len = int'(in_word_index) + 1;
      if (in_last_in) predict_product();
    end
    if (rst_n && out_valid && out_ready) begin
      if (product_q.size() == 0) begin
        $error("result transfer with nothing expected: word %h", out_result_word);
        errors++;
      end else begin
        e = product_q.pop_front();
        if (out_result_word !== e.word) begin
          $error("result_word: expected %h, got %h", e.word, out_result_word);
          errors++;
        end
        if (out_result_index !== e.index) begin
          $error("result_index: expected %0d, got %0d", e.index, out_result_index);
          errors++;
        end
        if (out_last_out !== e.last) begin
          $error("last_out: expected %b, got %b", e.last, out_last_out);
          errors++;
        end
        if (out_bad_modulus !== e.bad) begin
          $error("bad_modulus: expected %b, got %b", e.bad, out_bad_modulus);
          errors++;
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      dog_count <= 0;
    end else if (dog_count >= DOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      dog_count <= dog_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random ready gaps, one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(16);
      if (hold_req) begin
        // long stall; the core waits on the result and stops taking input
        gap = 600;
        hold_req = 1'b0;
      end
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // --------------------------------------------------------------------------
  // Shared driver tasks
  // --------------------------------------------------------------------------
  task automatic send_word(input int idx, input word_t xw, input word_t yw,
                           input word_t mw, input bit last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(16);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_word_index <= idx[INDEX_W-1:0];
    in_x_word     <= xw;
    in_y_word     <= yw;
    in_m_word     <= mw;
    in_last_in    <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Sends op_* words 0..len-1 in shuffled order, sometimes with a rewrite;
  // every position below len is written, so no stale store is ever read.
  task automatic send_operation(input int len);
    int order[$];
    int k, tmp;
    for (int i = 0; i < len; i++) order.push_back(i);
    for (int i = len - 1; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = order[i]; order[i] = order[k]; order[k] = tmp;
    end
    if (len > 1 && $urandom_range(3) == 0) begin
      // stale word first, overwritten later in the same operation
      k = $urandom_range(len - 1);
      send_word(k, $urandom, $urandom, $urandom, 1'b0);
    end
    foreach (order[i])
      send_word(order[i], op_x[order[i]], op_y[order[i]], op_m[order[i]],
                i == order.size() - 1);
  endtask

  // Fills operands; mode picks the shape of the modulus.
  typedef enum int {M_ODD, M_SHORT, M_EVEN, M_ZERO} mod_kind_t;

  task automatic fill_random(input int len, input mod_kind_t kind);
    int top;
    for (int i = 0; i < len; i++) begin
      op_x[i] = $urandom;
      op_y[i] = $urandom;
      op_m[i] = $urandom;
    end
    case (kind)
      M_ODD: begin
        op_m[0][0] = 1'b1;
        if (op_m[len-1] == 0) op_m[len-1] = 32'h8000_0000;
      end
      M_SHORT: begin
        // upper modulus words zero: n can fall below the loaded length
        top = $urandom_range(len - 1);
        for (int i = top + 1; i < len; i++) op_m[i] = '0;
        op_m[0][0] = 1'b1;
      end
      M_EVEN: begin
        op_m[0][0] = 1'b0;
      end
      M_ZERO: begin
        for (int i = 0; i < len; i++) op_m[i] = '0;
      end
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_neg_inv(input word_t v);
    drain();
    repeat (IDLE_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    neg_inv = v;
  endtask

  task automatic random_op(input int len);
    int pick;
    pick = $urandom_range(19);
    fill_random(len, pick < 14 ? M_ODD : pick < 17 ? M_SHORT :
                     pick < 19 ? M_EVEN : M_ZERO);
    send_operation(len);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // all-zero operands, modulus one
    op_x[0] = '0; op_y[0] = '0; op_m[0] = 32'd1;
    send_operation(1);
    // all ones everywhere
    op_x[0] = '1; op_y[0] = '1; op_m[0] = '1;
    send_operation(1);
    // even modulus: derived factor is zero, reductions are plain shifts
    op_x[0] = 32'h1234_5678; op_y[0] = 32'h9abc_def0; op_m[0] = 32'h0000_1000;
    send_operation(1);
    // zero modulus
    op_x[0] = '1; op_y[0] = 32'h0000_0001; op_m[0] = '0;
    send_operation(1);
    // two words loaded, modulus only one word
    op_x[0] = '1; op_x[1] = '1; op_y[0] = '1; op_y[1] = '1;
    op_m[0] = 32'hffff_fffb; op_m[1] = '0;
    send_operation(2);
    // operands far above a small modulus
    for (int i = 0; i < 3; i++) begin
      op_x[i] = '1; op_y[i] = '1; op_m[i] = '0;
    end
    op_m[0] = 32'h0000_0003; op_m[1] = 32'h0000_0001;
    send_operation(3);
    // reduced operands
    op_x[0] = 32'd5; op_x[1] = '0; op_y[0] = '1; op_y[1] = 32'h0000_0001;
    op_m[0] = 32'hffff_ffff; op_m[1] = 32'h8000_0000;
    send_operation(2);
    // zero modulus over two loaded words
    fill_random(2, M_ZERO);
    send_operation(2);
  endtask

  task automatic test_register_settings();
    word_t settings[5];
    fill_random(2, M_ODD);
    settings[0] = 32'd0 - word_inv(op_m[0]);   // correct factor for that modulus
    settings[1] = 32'd1;
    settings[2] = 32'hffff_ffff;
    settings[3] = $urandom | 32'd1;
    settings[4] = 32'h8000_0000;
    write_neg_inv(settings[0]);
    send_operation(2);
    foreach (settings[s]) begin
      write_neg_inv(settings[s]);
      for (int k = 0; k < 3; k++) random_op($urandom_range(1, 3));
    end
    write_neg_inv('0);
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    for (int k = 0; k < 4; k++) random_op($urandom_range(1, 4));
  endtask

  task automatic test_drain_pause();
    random_op(3);
    drain();
    random_op(2);
  endtask

  task automatic test_random();
    int target;
    target = items_sent + 170;
    random_op(MAXW);                 // full-width operation, all positions
    while (items_sent < target) begin
      if ($urandom_range(15) == 0) no_gaps = ~no_gaps;
      if ($urandom_range(60) == 0) begin
        no_gaps = 1'b0;
        write_neg_inv($urandom_range(1) ? '0 : $urandom);
      end
      case ($urandom_range(19))
        0:       random_op($urandom_range(5, 16));
        default: random_op($urandom_range(1, 4));
      endcase
    end
    no_gaps = 1'b0;
    random_op(MAXW);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_word_index = '0;
    in_x_word     = '0;
    in_y_word     = '0;
    in_m_word     = '0;
    in_last_in    = 1'b0;
    errors        = 0;
    items_sent    = 0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    loaded_len    = 0;
    neg_inv       = '0;
    dog_count     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_register_settings();
    test_output_stall();
    test_drain_pause();
    test_random();

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mmm_pkg.sv
rtl/mmm_inv.sv
rtl/montgomery_modular_multiplier_core.sv
sim/tb_montgomery_modular_multiplier_core.sv
